FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, gated by reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/ubds_pkg.sv
`default_nettype none
package ubds_pkg;

   localparam int CLK_W = 26;
   localparam int BAUD_W = 22;
   localparam int BQ_W = 16;
   localparam int RATIO_W = 6;
   localparam int DIVOUT_W = 13;

   localparam logic [9:0] KHZ_TO_HZ = 10'd1000;
   // floor(x/100) == (x * RECIP_100) >> RECIP_SHIFT for x below 2^22
   localparam logic [22:0] RECIP_100 = 23'd5368710;
   localparam int RECIP_SHIFT = 29;
   localparam logic [RATIO_W-1:0] MIN_RATIO = 6'd4;
   localparam logic [RATIO_W-1:0] BOTH_EDGE_LIMIT = 6'd9;
   localparam logic [DIVOUT_W-1:0] DIVISOR_MAX = 13'd8191;
   localparam int DIV_STEPS_PER_CYCLE = 2;
   localparam logic [3:0] DIV_LAST_CNT = 4'd12;

   typedef struct packed {
      logic [CLK_W-1:0]  clk_hz;
      logic [BAUD_W-1:0] baud;
      logic [BQ_W-1:0]   baud_div100;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_DIV1,
      ST_MUL2,
      ST_DIV2,
      ST_EVAL,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: hdl/ubds_front.sv
`default_nettype none
module ubds_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [15:0]          req_clock_khz,
   input  wire logic [21:0]          req_target_baud,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output ubds_pkg::item_type        push_item
);

   logic               valid_ff;
   ubds_pkg::item_type item_ff;
   ubds_pkg::item_type item_in;
   logic [44:0]        bprod;

   assign req_ready = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_item = item_ff;

   always_comb begin
      item_in.clk_hz = 26'(req_clock_khz) * 26'(ubds_pkg::KHZ_TO_HZ);
      item_in.baud = req_target_baud;
      bprod = 45'(req_target_baud) * 45'(ubds_pkg::RECIP_100);
      item_in.baud_div100 = bprod[44:ubds_pkg::RECIP_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/ubds_fifo.sv
`default_nettype none
module ubds_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire ubds_pkg::item_type  push_item,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output ubds_pkg::item_type       pop_item
);

   ubds_pkg::item_type mem_ff [2];
   logic               wr_ff;
   logic               rd_ff;
   logic [1:0]         count_ff;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_item = mem_ff[rd_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= !wr_ff;
         if (do_pop) rd_ff <= !rd_ff;
         if (do_push && !do_pop) count_ff <= count_ff + 2'd1;
         else if (do_pop && !do_push) count_ff <= count_ff - 2'd1;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/ubds_back.sv
`default_nettype none
module ubds_back #(
   parameter int MAX_OVERSAMPLE = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   output logic                     pop_ready,
   input  wire ubds_pkg::item_type  pop_item,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [5:0]               rsp_oversample_ratio,
   output logic [12:0]              rsp_baud_divisor,
   output logic                     rsp_both_edge,
   output logic                     rsp_config_ok
);

   localparam logic [5:0] RATIO_LAST = 6'(MAX_OVERSAMPLE);

   ubds_pkg::state_type state_ff, state_in;
   ubds_pkg::item_type  item_ff;
   logic [5:0]   ratio_ff;
   logic [26:0]  divisor_ff;
   logic [26:0]  rem_ff;
   logic [25:0]  quo_ff;
   logic [3:0]   cnt_ff;
   logic [25:0]  d_ff;
   logic         found_ff;
   logic [25:0]  best_err_ff;
   logic [5:0]   best_ratio_ff;
   logic [25:0]  best_div_ff;
   logic         rsp_valid_ff;
   logic [5:0]   ratio_out_ff;
   logic [12:0]  div_out_ff;
   logic         edge_out_ff;
   logic         ok_out_ff;

   logic [26:0]  rem_t;
   logic [25:0]  quo_t;
   logic [27:0]  trial;
   logic [25:0]  err;
   logic [17:0]  bound;
   logic         out_free;
   logic         div_done;

   assign pop_ready = (state_ff == ubds_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_oversample_ratio = ratio_out_ff;
   assign rsp_baud_divisor = div_out_ff;
   assign rsp_both_edge = edge_out_ff;
   assign rsp_config_ok = ok_out_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign div_done = (cnt_ff == 4'd0);

   // restoring divider, two quotient bits a cycle
   always_comb begin
      rem_t = rem_ff;
      quo_t = quo_ff;
      trial = '0;
      for (int i = 0; i < ubds_pkg::DIV_STEPS_PER_CYCLE; i++) begin
         trial = {rem_t, quo_t[25]};
         quo_t = {quo_t[24:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_t = 27'(trial - {1'b0, divisor_ff});
            quo_t[0] = 1'b1;
         end else begin
            rem_t = trial[26:0];
         end
      end
   end

   always_comb begin
      if (quo_ff >= 26'(item_ff.baud)) err = quo_ff - 26'(item_ff.baud);
      else err = 26'(item_ff.baud) - quo_ff;
      bound = 18'({item_ff.baud_div100, 1'b0}) + 18'(item_ff.baud_div100);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ubds_pkg::ST_IDLE: begin
            if (pop_valid) begin
               state_in = (pop_item.baud == '0) ? ubds_pkg::ST_DONE : ubds_pkg::ST_MUL1;
            end
         end
         ubds_pkg::ST_MUL1: state_in = ubds_pkg::ST_DIV1;
         ubds_pkg::ST_DIV1: begin
            if (div_done) begin
               if (quo_t != '0) state_in = ubds_pkg::ST_MUL2;
               else if (ratio_ff == RATIO_LAST) state_in = ubds_pkg::ST_DONE;
               else state_in = ubds_pkg::ST_MUL1;
            end
         end
         ubds_pkg::ST_MUL2: state_in = ubds_pkg::ST_DIV2;
         ubds_pkg::ST_DIV2: if (div_done) state_in = ubds_pkg::ST_EVAL;
         ubds_pkg::ST_EVAL: begin
            state_in = (ratio_ff == RATIO_LAST) ? ubds_pkg::ST_DONE : ubds_pkg::ST_MUL1;
         end
         ubds_pkg::ST_DONE: if (out_free) state_in = ubds_pkg::ST_IDLE;
         default: state_in = ubds_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ubds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ubds_pkg::ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end

      case (state_ff)
         ubds_pkg::ST_IDLE: begin
            item_ff <= pop_item;
            ratio_ff <= ubds_pkg::MIN_RATIO;
            found_ff <= 1'b0;
            best_err_ff <= '0;
            best_ratio_ff <= ubds_pkg::MIN_RATIO;
            best_div_ff <= '0;
         end
         ubds_pkg::ST_MUL1: begin
            divisor_ff <= 27'(item_ff.baud) * 27'(ratio_ff);
            rem_ff <= '0;
            quo_ff <= item_ff.clk_hz;
            cnt_ff <= ubds_pkg::DIV_LAST_CNT;
         end
         ubds_pkg::ST_DIV1: begin
            rem_ff <= rem_t;
            quo_ff <= quo_t;
            cnt_ff <= cnt_ff - 4'd1;
            if (div_done) begin
               d_ff <= quo_t;
               if (quo_t == '0) ratio_ff <= ratio_ff + 6'd1;
            end
         end
         ubds_pkg::ST_MUL2: begin
            divisor_ff <= 27'(d_ff * 26'(ratio_ff));
            rem_ff <= '0;
            quo_ff <= item_ff.clk_hz;
            cnt_ff <= ubds_pkg::DIV_LAST_CNT;
         end
         ubds_pkg::ST_DIV2: begin
            rem_ff <= rem_t;
            quo_ff <= quo_t;
            cnt_ff <= cnt_ff - 4'd1;
         end
         ubds_pkg::ST_EVAL: begin
            if (!found_ff || err <= best_err_ff) begin
               found_ff <= 1'b1;
               best_err_ff <= err;
               best_ratio_ff <= ratio_ff;
               best_div_ff <= d_ff;
            end
            ratio_ff <= ratio_ff + 6'd1;
         end
         ubds_pkg::ST_DONE: begin
            if (out_free) begin
               ratio_out_ff <= best_ratio_ff;
               edge_out_ff <= (best_ratio_ff < ubds_pkg::BOTH_EDGE_LIMIT);
               div_out_ff <= (best_div_ff > 26'(ubds_pkg::DIVISOR_MAX)) ?
                             ubds_pkg::DIVISOR_MAX : best_div_ff[12:0];
               ok_out_ff <= found_ff && (best_err_ff < 26'(bound)) &&
                            (best_div_ff <= 26'(ubds_pkg::DIVISOR_MAX));
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: hdl/uart_baud_divisor_search_core.sv
// Per oversample ratio, the search runs a multiply and a division; a nonzero quotient
// adds a second multiply and division and a compare step.
// The shared divider bounds the response rate, while a 2-entry queue lets new requests land.
// Reset: synchronous, active high; clears handshake and sequencer state only.
`default_nettype none
`include "assert_macros.svh"
module uart_baud_divisor_search_core #(
   parameter int MAX_OVERSAMPLE = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [15:0]   req_clock_khz,
   input  wire logic [21:0]   req_target_baud,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [5:0]         rsp_oversample_ratio,
   output logic [12:0]        rsp_baud_divisor,
   output logic               rsp_both_edge,
   output logic               rsp_config_ok
);

   localparam logic [5:0] RATIO_MAX = 6'(MAX_OVERSAMPLE);

   logic               push_valid;
   logic               push_ready;
   ubds_pkg::item_type push_item;
   logic               pop_valid;
   logic               pop_ready;
   ubds_pkg::item_type pop_item;
   logic               ratio_in_range;
   logic               ratio_narrow;

   assign ratio_in_range = (rsp_oversample_ratio >= ubds_pkg::MIN_RATIO) &&
                           (rsp_oversample_ratio <= RATIO_MAX);
   assign ratio_narrow = (rsp_oversample_ratio < ubds_pkg::BOTH_EDGE_LIMIT);

   ubds_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_clock_khz, .req_target_baud,
      .push_valid, .push_ready, .push_item
   );

   ubds_fifo u_fifo (
      .clock, .reset, .push_valid, .push_ready, .push_item,
      .pop_valid, .pop_ready, .pop_item
   );

   ubds_back #(.MAX_OVERSAMPLE(MAX_OVERSAMPLE)) u_back (
      .clock, .reset, .pop_valid, .pop_ready, .pop_item,
      .rsp_valid, .rsp_ready, .rsp_oversample_ratio, .rsp_baud_divisor,
      .rsp_both_edge, .rsp_config_ok
   );

   `ASSERT_IMPLIES(a_ratio_range, clock, reset, rsp_valid, ratio_in_range)
   `ASSERT_IMPLIES(a_both_edge, clock, reset, rsp_valid, rsp_both_edge == ratio_narrow)
   `ASSERT_IMPLIES(a_ok_nonzero_div, clock, reset, rsp_valid && rsp_config_ok, rsp_baud_divisor != '0)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_baud_divisor))

endmodule
`default_nettype wire
